[src/dteq_pkg.sv]
// Package for the deduplicated timed event queue.
// Holds sizes, codes, item and cell types and the event ordering helpers.
// No dependencies.
package dteq_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int KEY_DEPTH   = 256;
	localparam int MAX_BUDGET  = 63;
	localparam int CW          = $clog2(QUEUE_DEPTH + 1);
	localparam int KCW         = $clog2(KEY_DEPTH + 1);
	localparam int BUF_DEPTH   = 64;
	localparam int BAW         = $clog2(BUF_DEPTH);

	typedef enum logic [1:0] {
		MODE_SCHED   = 2'd0,
		MODE_RESCHED = 2'd1,
		MODE_DRAIN   = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_EVENT = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [63:0]        tick;
		logic [31:0]        seq;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [3:0]         action;
	} entry_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [63:0]        tick;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [3:0]         action;
		logic [5:0]         budget;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [63:0]        event_tick;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [3:0]         out_action;
		logic [5:0]         drained_count;
		logic [CW-1:0]      queue_size;
		logic [1:0]         status;
		logic               last;
	} out_item_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   new_e;
	} cell_ctrl_t;

	typedef struct packed {
		entry_t e;
		logic   valid;
		logic   live;
		logic   live_fwd;
		logic   less;
		logic   match;
	} cell_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DRAIN,
		S_RD,
		S_LOAD,
		S_OUT
	} fsm_t;

	// a comes out ahead of b: earlier tick, then lower sequence
	function automatic logic ahead_of(entry_t a, entry_t b);
		return (a.tick < b.tick) || ((a.tick == b.tick) && (a.seq < b.seq));
	endfunction

	function automatic logic key_eq(entry_t a, entry_t b);
		return (a.x == b.x) && (a.y == b.y) && (a.z == b.z) && (a.action == b.action);
	endfunction

endpackage

[src/dteq_if.sv]
// Stream interfaces for the input and result channels of the event queue.
// Depends on dteq_pkg for the queue size width; other widths follow the item fields.
interface dteq_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [63:0]        tick;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [3:0]         action;
	logic [5:0]         budget;
	modport source(output valid, mode, tick, pos_x, pos_y, pos_z, action, budget,
		input ready);
	modport sink(input valid, mode, tick, pos_x, pos_y, pos_z, action, budget,
		output ready);
endinterface

interface dteq_out_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              kind;
	logic [63:0]             event_tick;
	logic signed [31:0]      out_x;
	logic signed [31:0]      out_y;
	logic signed [31:0]      out_z;
	logic [3:0]              out_action;
	logic [5:0]              drained_count;
	logic [dteq_pkg::CW-1:0] queue_size;
	logic [1:0]              status;
	logic                    last;
	modport source(output valid, kind, event_tick, out_x, out_y, out_z, out_action,
		drained_count, queue_size, status, last, input ready);
	modport sink(input valid, kind, event_tick, out_x, out_y, out_z, out_action,
		drained_count, queue_size, status, last, output ready);
endinterface

[src/dteq_cell.sv]
// One slot of the sorted event chain.
// Depends on dteq_pkg; shifts right on insert, left on pop.
module dteq_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dteq_pkg::cell_ctrl_t  ctrl,
	input  dteq_pkg::cell_out_t   prev,
	input  dteq_pkg::cell_out_t   next,
	output dteq_pkg::cell_out_t   co
);
	dteq_pkg::entry_t entry_q;
	logic             valid_q;
	logic             live_q;
	logic             keyeq;

	// compare own entry against the item being inserted
	always_comb begin
		keyeq       = dteq_pkg::key_eq(ctrl.new_e, entry_q);
		co.e        = entry_q;
		co.valid    = valid_q;
		co.live     = live_q;
		co.live_fwd = live_q & ~keyeq;
		co.less     = ~valid_q | dteq_pkg::ahead_of(ctrl.new_e, entry_q);
		co.match    = valid_q & live_q & keyeq;
	end

	// update valid and live flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			live_q  <= 1'b0;
		end else begin
			case (ctrl.op)
				dteq_pkg::CELL_INSERT: begin
					if (prev.less) begin
						valid_q <= prev.valid;
						live_q  <= prev.live_fwd;
					end else if (co.less) begin
						valid_q <= 1'b1;
						live_q  <= 1'b1;
					end else begin
						live_q  <= co.live_fwd;
					end
				end
				dteq_pkg::CELL_POP: begin
					valid_q <= next.valid;
					live_q  <= next.live;
				end
				dteq_pkg::CELL_CLEAR: begin
					valid_q <= 1'b0;
					live_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// move the payload along the chain
	always_ff @(posedge clk) begin
		case (ctrl.op)
			dteq_pkg::CELL_INSERT: begin
				if (prev.less)
					entry_q <= prev.e;
				else if (co.less)
					entry_q <= ctrl.new_e;
			end
			dteq_pkg::CELL_POP: entry_q <= next.e;
			default: ;
		endcase
	end
endmodule

[src/dteq_rbuf.sv]
// Result buffer that holds due events until the drain is finished.
// Depends on dteq_pkg; one write port, one registered read port.
module dteq_rbuf (
	input  logic                          clk,
	input  logic                          we,
	input  logic [dteq_pkg::BAW-1:0]      waddr,
	input  dteq_pkg::entry_t              wdata,
	input  logic [dteq_pkg::BAW-1:0]      raddr,
	output dteq_pkg::entry_t              rdata
);
	dteq_pkg::entry_t mem [dteq_pkg::BUF_DEPTH];

	// write popped event, read next one to emit
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[src/deduplicated_timed_event_queue_unit.sv]
// Deduplicated timed event queue: a sorted chain of QUEUE_DEPTH cells holds the
// pending events in order of tick, then sequence, each with a live flag that
// later reschedules of its key clear. One item is handled at a time. Schedule,
// reschedule and clear pass the execute state after the input transfer (key search
// and chain shift happen in one step across all cells) before the result is offered.
// A drain pops due head entries, stale ones included, and writes the live ones to
// the result buffer; it reads each emitted event back from the result buffer and
// offers it, then the summary, each held until its output transfer. The chain pops
// one head entry per cycle.
module deduplicated_timed_event_queue_unit (
	input  logic          clk,
	input  logic          arst_n,
	dteq_in_if.sink       in_ch,
	dteq_out_if.source    out_ch
);
	localparam int N = dteq_pkg::QUEUE_DEPTH;

	dteq_pkg::fsm_t        state_q, state_d;
	dteq_pkg::in_item_t    in_q;
	dteq_pkg::out_item_t   out_q;
	logic [5:0]            cnt_q;
	logic [5:0]            rd_q;
	logic [dteq_pkg::CW-1:0]  count_q;
	logic [dteq_pkg::KCW-1:0] live_cnt_q;
	logic [31:0]           seq_q;

	dteq_pkg::cell_ctrl_t  ctrl;
	dteq_pkg::cell_out_t   co [N];
	logic [N-1:0]          match_vec;
	logic                  any_match;
	logic                  is_ins;
	logic [1:0]            st;
	logic                  ins_ok;
	logic [5:0]            limit;
	logic                  pop_ok;
	logic                  pop_live;
	logic [dteq_pkg::CW-1:0]  count_after;
	dteq_pkg::entry_t      rdata;

	// build the cell chain
	for (genvar i = 0; i < N; i++) begin : g_cell
		dteq_pkg::cell_out_t p, n;
		if (i == 0) begin : g_first
			assign p = '0;
		end else begin : g_mid
			assign p = co[i-1];
		end
		if (i == N - 1) begin : g_last
			assign n = '0;
		end else begin : g_more
			assign n = co[i+1];
		end
		dteq_cell u_cell (.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .prev(p), .next(n),
			.co(co[i]));
		assign match_vec[i] = co[i].match;
	end

	assign any_match = |match_vec;

	// decide the insert outcome and the drain step
	always_comb begin
		is_ins = (in_q.mode == dteq_pkg::MODE_SCHED) || (in_q.mode == dteq_pkg::MODE_RESCHED);
		if ((in_q.mode == dteq_pkg::MODE_SCHED) && any_match)
			st = dteq_pkg::ST_DUP;
		else if (count_q >= dteq_pkg::CW'(dteq_pkg::QUEUE_DEPTH))
			st = dteq_pkg::ST_FULL;
		else if (!any_match && (live_cnt_q >= dteq_pkg::KCW'(dteq_pkg::KEY_DEPTH)))
			st = dteq_pkg::ST_FULL;
		else
			st = dteq_pkg::ST_OK;
		if (!is_ins)
			st = dteq_pkg::ST_OK;
		ins_ok = is_ins && (st == dteq_pkg::ST_OK);
		limit = (in_q.budget > 6'(dteq_pkg::MAX_BUDGET)) ? 6'(dteq_pkg::MAX_BUDGET)
			: in_q.budget;
		pop_ok = (state_q == dteq_pkg::S_DRAIN) && (cnt_q < limit) && co[0].valid
			&& (co[0].e.tick <= in_q.tick);
		pop_live = pop_ok && co[0].live;
		if (ins_ok)
			count_after = count_q + dteq_pkg::CW'(1);
		else if (in_q.mode == dteq_pkg::MODE_CLEAR)
			count_after = '0;
		else
			count_after = count_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dteq_pkg::S_IDLE:  if (in_ch.valid) state_d = dteq_pkg::S_EXEC;
			dteq_pkg::S_EXEC:  state_d = (in_q.mode == dteq_pkg::MODE_DRAIN)
				? dteq_pkg::S_DRAIN : dteq_pkg::S_OUT;
			dteq_pkg::S_DRAIN: if (!pop_ok) state_d = dteq_pkg::S_RD;
			dteq_pkg::S_RD:    state_d = (rd_q < cnt_q) ? dteq_pkg::S_LOAD : dteq_pkg::S_OUT;
			dteq_pkg::S_LOAD:  state_d = dteq_pkg::S_OUT;
			dteq_pkg::S_OUT: begin
				if (out_ch.ready)
					state_d = out_q.last ? dteq_pkg::S_IDLE : dteq_pkg::S_RD;
			end
			default: state_d = dteq_pkg::S_IDLE;
		endcase
	end

	// outputs: handshakes and chain command
	always_comb begin
		in_ch.ready  = (state_q == dteq_pkg::S_IDLE);
		out_ch.valid = (state_q == dteq_pkg::S_OUT);
		ctrl.new_e.tick   = in_q.tick;
		ctrl.new_e.seq    = seq_q;
		ctrl.new_e.x      = in_q.pos_x;
		ctrl.new_e.y      = in_q.pos_y;
		ctrl.new_e.z      = in_q.pos_z;
		ctrl.new_e.action = in_q.action;
		if ((state_q == dteq_pkg::S_EXEC) && ins_ok)
			ctrl.op = dteq_pkg::CELL_INSERT;
		else if ((state_q == dteq_pkg::S_EXEC) && (in_q.mode == dteq_pkg::MODE_CLEAR))
			ctrl.op = dteq_pkg::CELL_CLEAR;
		else if (pop_ok)
			ctrl.op = dteq_pkg::CELL_POP;
		else
			ctrl.op = dteq_pkg::CELL_HOLD;
	end

	assign out_ch.kind          = out_q.kind;
	assign out_ch.event_tick    = out_q.event_tick;
	assign out_ch.out_x         = out_q.out_x;
	assign out_ch.out_y         = out_q.out_y;
	assign out_ch.out_z         = out_q.out_z;
	assign out_ch.out_action    = out_q.out_action;
	assign out_ch.drained_count = out_q.drained_count;
	assign out_ch.queue_size    = out_q.queue_size;
	assign out_ch.status        = out_q.status;
	assign out_ch.last          = out_q.last;

	dteq_rbuf u_rbuf (.clk(clk), .we(pop_live), .waddr(cnt_q[dteq_pkg::BAW-1:0]),
		.wdata(co[0].e), .raddr(rd_q[dteq_pkg::BAW-1:0]), .rdata(rdata));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dteq_pkg::S_IDLE;
			cnt_q      <= '0;
			rd_q       <= '0;
			count_q    <= '0;
			live_cnt_q <= '0;
			seq_q      <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				dteq_pkg::S_IDLE: begin
					cnt_q <= '0;
					rd_q  <= '0;
				end
				dteq_pkg::S_EXEC: begin
					count_q <= count_after;
					if (ins_ok) begin
						seq_q <= seq_q + 32'd1;
						if (!any_match)
							live_cnt_q <= live_cnt_q + dteq_pkg::KCW'(1);
					end else if (in_q.mode == dteq_pkg::MODE_CLEAR) begin
						live_cnt_q <= '0;
					end
				end
				dteq_pkg::S_DRAIN: begin
					if (pop_ok)
						count_q <= count_q - dteq_pkg::CW'(1);
					if (pop_live) begin
						live_cnt_q <= live_cnt_q - dteq_pkg::KCW'(1);
						cnt_q      <= cnt_q + 6'd1;
					end
				end
				dteq_pkg::S_RD: if (rd_q < cnt_q) rd_q <= rd_q + 6'd1;
				default: ;
			endcase
		end
	end

	// payload registers: hold the input, build result items
	always_ff @(posedge clk) begin
		if ((state_q == dteq_pkg::S_IDLE) && in_ch.valid) begin
			in_q.mode   <= in_ch.mode;
			in_q.tick   <= in_ch.tick;
			in_q.pos_x  <= in_ch.pos_x;
			in_q.pos_y  <= in_ch.pos_y;
			in_q.pos_z  <= in_ch.pos_z;
			in_q.action <= in_ch.action;
			in_q.budget <= in_ch.budget;
		end
		case (state_q)
			dteq_pkg::S_EXEC: begin
				out_q            <= '0;
				out_q.kind       <= dteq_pkg::KIND_ACK;
				out_q.status     <= st;
				out_q.queue_size <= count_after;
				out_q.last       <= 1'b1;
			end
			dteq_pkg::S_RD: begin
				if (!(rd_q < cnt_q)) begin
					out_q               <= '0;
					out_q.kind          <= dteq_pkg::KIND_DONE;
					out_q.drained_count <= cnt_q;
					out_q.queue_size    <= count_q;
					out_q.last          <= 1'b1;
				end
			end
			dteq_pkg::S_LOAD: begin
				out_q            <= '0;
				out_q.kind       <= dteq_pkg::KIND_EVENT;
				out_q.event_tick <= rdata.tick;
				out_q.out_x      <= rdata.x;
				out_q.out_y      <= rdata.y;
				out_q.out_z      <= rdata.z;
				out_q.out_action <= rdata.action;
				out_q.queue_size <= count_q;
			end
			default: ;
		endcase
	end
endmodule

[src/dteq_checker.sv]
// Port-level checks for the event queue, attached to the top level by bind.
// Depends on dteq_pkg codes and the top level's channel ports.
module dteq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [1:0] out_status,
	input logic       out_last
);
	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// one item at a time: no intake while a result is offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while result pending");

	// an input transfer closes intake next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("intake open right after transfer");

	// summary ends the drain
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == dteq_pkg::KIND_DONE) |-> out_last)
		else $error("summary not marked last");

	// due events are never last and carry no status
	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == dteq_pkg::KIND_EVENT) |-> !out_last
		&& (out_status == dteq_pkg::ST_OK))
		else $error("malformed due event");
endmodule

bind deduplicated_timed_event_queue_unit dteq_checker u_dteq_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_kind(out_ch.kind), .out_status(out_ch.status), .out_last(out_ch.last)
);
